FILE: hdl/agh_pkg.sv
// Package: shared constants, types and codes of the alert gate.
`timescale 1ns / 1ps
`default_nettype none
package agh_pkg;

   localparam int HOSTS       = 64;
   localparam int HOST_W      = 6;
   localparam int HOST_AW     = (HOSTS > 1) ? $clog2(HOSTS) : 1;
   localparam int HOST_IW     = (HOST_AW > HOST_W) ? HOST_AW : HOST_W;
   localparam int TIME_WIDTH  = 48;
   localparam int COUNT_W     = 8;
   localparam int SCORE_W     = 32;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 32;

   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   localparam logic [7:0]         THRESHOLD_RESET = 8'd3;
   localparam logic [31:0]        COOLDOWN_RESET  = 32'd60;
   localparam logic [SCORE_W-1:0] HIGH_LIMIT_RESET = 32'sd655360;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_THRESHOLD  = 2'd0,
      CSR_COOLDOWN   = 2'd1,
      CSR_HIGH_LIMIT = 2'd2
   } csr_index_type;

   localparam logic [1:0] SEV_MEDIUM   = 2'd0;
   localparam logic [1:0] SEV_HIGH     = 2'd1;
   localparam logic [1:0] SEV_CRITICAL = 2'd2;

   localparam logic [1:0] SRC_DET_A  = 2'd0;
   localparam logic [1:0] SRC_DET_B  = 2'd1;
   localparam logic [1:0] SRC_FUSION = 2'd2;

   typedef enum logic {
      ST_IDLE,
      ST_CALC
   } state_type;

   typedef struct packed {
      logic [COUNT_W-1:0]    count;
      logic [TIME_WIDTH-1:0] last_time;
   } host_entry_type;

endpackage
`default_nettype wire

FILE: hdl/agh_host_table.sv
// Per-host state table: synchronous RAM with per-entry valid bits cleared at reset.
`timescale 1ns / 1ps
`default_nettype none
module agh_host_table
   import agh_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                rd_en,
   input  wire logic [HOST_AW-1:0]  rd_idx,
   output host_entry_type           rd_entry,
   input  wire logic                wr_en,
   input  wire logic [HOST_AW-1:0]  wr_idx,
   input  wire host_entry_type      wr_entry
);

   host_entry_type           mem [HOSTS];
   host_entry_type           rd_data_ff;
   logic [HOSTS-1:0]         valid_ff;
   logic [HOSTS-1:0]         valid_in;
   logic                     rd_valid_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_idx] <= wr_entry;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_idx];
      end
   end

   always_comb begin
      valid_in = valid_ff;
      if (wr_en) begin
         valid_in[wr_idx] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         if (rd_en) begin
            rd_valid_ff <= valid_ff[rd_idx];
         end
      end
   end

   assign rd_entry = rd_valid_ff ? rd_data_ff : '0;

endmodule
`default_nettype wire

FILE: hdl/alert_gate_hysteresis_cooldown_core.sv
// Top level: per-host alert gate with hysteresis count and cooldown timer.
// rsp_valid is registered: table read, ST_CALC update, then rsp_valid_ff on an alert.
// A new event is not accepted until the host table read and write-back are done.
// busy is high during the update cycle and during reset; no forwarding is needed.
// Reset clears the configuration to defaults and marks every host entry as zero.
// The receiver cannot stall: rsp_valid is a one-cycle strobe.
`timescale 1ns / 1ps
`default_nettype none
module alert_gate_hysteresis_cooldown_core
   import agh_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   start,
   output logic                        busy,
   input  wire logic [HOST_W-1:0]      req_host,
   input  wire logic [TIME_WIDTH-1:0]  req_time_stamp,
   input  wire logic                   req_flag_a,
   input  wire logic signed [SCORE_W-1:0] req_score_a,
   input  wire logic                   req_flag_b,
   input  wire logic signed [SCORE_W-1:0] req_score_b,
   input  wire logic                   csr_we,
   input  wire logic [CSR_IDX_W-1:0]   csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata,
   output logic                        rsp_valid,
   output logic [HOST_W-1:0]           rsp_alert_host,
   output logic [TIME_WIDTH-1:0]       rsp_alert_time,
   output logic [1:0]                  rsp_severity,
   output logic [1:0]                  rsp_source,
   output logic signed [SCORE_W-1:0]   rsp_alert_score
);

   state_type                   state_ff, state_in;
   logic                        accept;

   logic [7:0]                  threshold_ff;
   logic [31:0]                 cooldown_ff;
   logic signed [SCORE_W-1:0]   high_limit_ff;

   logic [HOST_W-1:0]           host_ff;
   logic [TIME_WIDTH-1:0]       time_ff;
   logic                        flag_a_ff, flag_b_ff;
   logic signed [SCORE_W-1:0]   score_a_ff, score_b_ff;
   logic                        in_range_ff;

   logic [HOST_IW-1:0]          req_host_ext;
   logic [HOST_IW-1:0]          host_ext;
   logic [HOST_AW-1:0]          rd_idx;
   logic [HOST_AW-1:0]          wr_idx;

   host_entry_type              rd_entry;
   host_entry_type              wr_entry;
   logic                        wr_en;

   logic [COUNT_W-1:0]          count_inc;
   logic [TIME_WIDTH-1:0]       elapsed;
   logic                        flagged;
   logic                        pass_hyst;
   logic                        cooled;
   logic                        emit;
   logic [1:0]                  sev_in, src_in;
   logic signed [SCORE_W-1:0]   score_in;

   logic                        rsp_valid_ff, rsp_valid_in;
   logic [HOST_W-1:0]           rsp_host_ff;
   logic [TIME_WIDTH-1:0]       rsp_time_ff;
   logic [1:0]                  rsp_sev_ff, rsp_src_ff;
   logic signed [SCORE_W-1:0]   rsp_score_ff;

   // config
   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff  <= THRESHOLD_RESET;
         cooldown_ff   <= COOLDOWN_RESET;
         high_limit_ff <= HIGH_LIMIT_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_THRESHOLD:  threshold_ff  <= csr_wdata[7:0];
            CSR_COOLDOWN:   cooldown_ff   <= csr_wdata[31:0];
            CSR_HIGH_LIMIT: high_limit_ff <= csr_wdata[SCORE_W-1:0];
            default: ;
         endcase
      end
   end

   // control
   assign busy   = reset || (state_ff == ST_CALC);
   assign accept = start && !busy;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_CALC;
            end
         end
         ST_CALC: begin
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // event capture
   assign req_host_ext = HOST_IW'(req_host);
   assign rd_idx       = req_host_ext[HOST_AW-1:0];

   always_ff @(posedge clock) begin
      if (accept) begin
         host_ff     <= req_host;
         time_ff     <= req_time_stamp;
         flag_a_ff   <= req_flag_a;
         flag_b_ff   <= req_flag_b;
         score_a_ff  <= req_score_a;
         score_b_ff  <= req_score_b;
         in_range_ff <= (32'(req_host) < 32'(HOSTS));
      end
   end

   agh_host_table u_table (
      .clock    (clock),
      .reset    (reset),
      .rd_en    (accept),
      .rd_idx   (rd_idx),
      .rd_entry (rd_entry),
      .wr_en    (wr_en),
      .wr_idx   (wr_idx),
      .wr_entry (wr_entry)
   );

   // update
   assign host_ext = HOST_IW'(host_ff);
   assign wr_idx   = host_ext[HOST_AW-1:0];

   always_comb begin
      flagged   = flag_a_ff || flag_b_ff;
      count_inc = (rd_entry.count == COUNT_MAX) ? rd_entry.count
                                                : rd_entry.count + COUNT_W'(1);
      pass_hyst = (count_inc >= threshold_ff);
      elapsed   = time_ff - rd_entry.last_time;
      cooled    = !elapsed[TIME_WIDTH-1] && (elapsed >= TIME_WIDTH'(cooldown_ff));
      emit      = flagged && pass_hyst &&
                  ((rd_entry.last_time == '0) || cooled);

      wr_en              = (state_ff == ST_CALC) && in_range_ff;
      wr_entry.last_time = emit ? time_ff : rd_entry.last_time;
      if (!flagged || emit) begin
         wr_entry.count = '0;
      end else begin
         wr_entry.count = count_inc;
      end

      if (flag_a_ff && flag_b_ff) begin
         sev_in   = SEV_CRITICAL;
         src_in   = SRC_FUSION;
         score_in = (score_a_ff > score_b_ff) ? score_a_ff : score_b_ff;
      end else if (flag_b_ff) begin
         sev_in   = SEV_HIGH;
         src_in   = SRC_DET_B;
         score_in = score_b_ff;
      end else begin
         sev_in   = (score_a_ff > high_limit_ff) ? SEV_HIGH : SEV_MEDIUM;
         src_in   = SRC_DET_A;
         score_in = score_a_ff;
      end

      rsp_valid_in = wr_en && emit;
   end

   // result word
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_valid_in) begin
         rsp_host_ff  <= host_ff;
         rsp_time_ff  <= time_ff;
         rsp_sev_ff   <= sev_in;
         rsp_src_ff   <= src_in;
         rsp_score_ff <= score_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_alert_host  = rsp_host_ff;
   assign rsp_alert_time  = rsp_time_ff;
   assign rsp_severity    = rsp_sev_ff;
   assign rsp_source      = rsp_src_ff;
   assign rsp_alert_score = rsp_score_ff;

endmodule
`default_nettype wire
